/* design/vpc_pkg.sv */
package vpc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int OUT_BITS    = SAMPLE_BITS + 3;
  localparam int IN_TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;

  localparam int WEIGHT_BITS = 17;
  localparam int WEIGHT_FRAC = 14;
  localparam int WPROD_BITS  = WEIGHT_BITS + SAMPLE_BITS + 1;
  localparam int WSUM_BITS   = WPROD_BITS + 1;

  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  typedef logic [SAMPLE_BITS-1:0]        sample_t;
  typedef logic signed [OUT_BITS-1:0]    result_t;
  typedef logic signed [WEIGHT_BITS-1:0] weight_t;
  typedef logic [3:0]                    op_t;

  typedef struct packed {
    op_t  op;
    logic clamp;
  } ctrl_t;

  localparam sample_t FULL          = '1;
  localparam weight_t WEIGHT_ONE    = weight_t'(1 << WEIGHT_FRAC);
  localparam weight_t WEIGHT_MAX    = weight_t'(2 << WEIGHT_FRAC);
  localparam weight_t WEIGHT_RESET  = weight_t'(1 << (WEIGHT_FRAC - 1));
  localparam int      WEIGHT_HALF   = 1 << (WEIGHT_FRAC - 1);

  // operation codes
  localparam op_t OP_MAX     = 4'd0;
  localparam op_t OP_MIN     = 4'd1;
  localparam op_t OP_ADD     = 4'd2;
  localparam op_t OP_SUB_AB  = 4'd3;
  localparam op_t OP_SUB_BA  = 4'd4;
  localparam op_t OP_MUL     = 4'd5;
  localparam op_t OP_AVG     = 4'd6;
  localparam op_t OP_WSUM    = 4'd7;
  localparam op_t OP_WSUM2   = 4'd8;
  localparam op_t OP_OVER    = 4'd9;
  localparam op_t OP_MASK_B  = 4'd10;
  localparam op_t OP_MASK_A  = 4'd11;
  localparam op_t OP_PRIO_A  = 4'd12;
  localparam op_t OP_PRIO_B  = 4'd13;
  localparam op_t OP_TAKE_A  = 4'd14;
  localparam op_t OP_TAKE_B  = 4'd15;

  // register indexes
  localparam logic [1:0] REG_OP    = 2'd0;
  localparam logic [1:0] REG_WC    = 2'd1;
  localparam logic [1:0] REG_WD    = 2'd2;
  localparam logic [1:0] REG_CLAMP = 2'd3;

  // saturate a written weight to -2.0..2.0
  function automatic weight_t sat_weight(input logic [WEIGHT_BITS-1:0] raw);
    weight_t w;
    w = weight_t'(raw);
    if (w > WEIGHT_MAX) begin
      return WEIGHT_MAX;
    end else if (w < -WEIGHT_MAX) begin
      return -WEIGHT_MAX;
    end
    return w;
  endfunction

endpackage

/* design/vpc_prod_round.sv */
module vpc_prod_round (
  input  logic                           clk,
  input  logic                           en,
  input  logic [vpc_pkg::PROD_BITS-1:0]  prod,
  output vpc_pkg::sample_t               quot
);
  import vpc_pkg::*;

  localparam int TW = PROD_BITS + 1;
  localparam int QW = SAMPLE_BITS + 1;

  logic [TW-1:0] t;
  logic [TW-1:0] s;
  logic [TW-1:0] qf;
  logic [QW-1:0] qe_nxt, qe_r;
  logic [QW-1:0] rem_nxt, rem_r;
  sample_t       quot_nxt, quot_r;

  // round(p / FULL) = floor((p + FULL/2) / FULL); estimate never overshoots
  // and is at most one short
  always_comb begin
    t       = TW'(prod) + TW'(FULL >> 1);
    s       = t + (t >> SAMPLE_BITS);
    qe_nxt  = QW'(s >> SAMPLE_BITS);
    qf      = (TW'(qe_nxt) << SAMPLE_BITS) - TW'(qe_nxt);
    rem_nxt = QW'(t - qf);
  end

  always_comb begin
    if (rem_r >= QW'(FULL)) begin
      quot_nxt = SAMPLE_BITS'(qe_r + QW'(1));
    end else begin
      quot_nxt = SAMPLE_BITS'(qe_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qe_r   <= qe_nxt;
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign quot = quot_r;

endmodule

/* design/voxel_pair_combiner.sv */
// Blend-mode ALU for pairs of normalised samples (all ones = 1.0). Takes one word per clock
// while the output is not stalled and returns one result word through a multiplier stage, a sum stage with the first
// half of the divide-by-full-scale rounding, a correction stage, and the select/saturate stage
// that loads the output register. A stalled output holds the whole pipeline; the input is
// ready whenever the output register is empty or being taken. Configure only while idle.
module voxel_pair_combiner (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [vpc_pkg::IN_TDATA_W-1:0]   in_tdata,   // value_a, value_b
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [vpc_pkg::OUT_TDATA_W-1:0]  out_tdata,  // combined_value
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [vpc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [vpc_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [vpc_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import vpc_pkg::*;

  // configuration
  op_t        op_r;
  weight_t    wc_r, wd_r;
  logic       clamp_r;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= OP_MAX;
      wc_r    <= WEIGHT_RESET;
      wd_r    <= WEIGHT_RESET;
      clamp_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_OP:    op_r    <= cfg_pwdata[3:0];
        REG_WC:    wc_r    <= sat_weight(cfg_pwdata[WEIGHT_BITS-1:0]);
        REG_WD:    wd_r    <= sat_weight(cfg_pwdata[WEIGHT_BITS-1:0]);
        REG_CLAMP: clamp_r <= cfg_pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_OP:    cfg_prdata = CFG_DATA_W'(op_r);
      REG_WC:    cfg_prdata = CFG_DATA_W'(wc_r);
      REG_WD:    cfg_prdata = CFG_DATA_W'(wd_r);
      REG_CLAMP: cfg_prdata = CFG_DATA_W'(clamp_r);
    endcase
  end

  // pipeline control: every stage moves together
  logic adv;
  logic v1_r, v2_r, v3_r, out_tvalid_r;

  assign adv        = out_tready | ~out_tvalid_r;
  assign in_tready  = adv;
  assign out_tvalid = out_tvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      v1_r         <= in_tvalid;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      out_tvalid_r <= v3_r;
    end
  end

  // stage 1: operand select and multiplies
  sample_t                       a_in, b_in, mx, my;
  weight_t                       we;
  logic signed [SAMPLE_BITS:0]   a_sx, b_sx;
  logic [PROD_BITS-1:0]          prod_nxt, prod1_r;
  logic signed [WPROD_BITS-1:0]  wpc_nxt, wpd_nxt, wpc1_r, wpd1_r;
  ctrl_t                         ctrl1_nxt, ctrl1_r;
  sample_t                       a1_r, b1_r;

  always_comb begin
    a_in      = in_tdata[SAMPLE_BITS-1:0];
    b_in      = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    mx        = (op_r == OP_OVER) ? b_in : a_in;
    my        = (op_r == OP_OVER) ? FULL - a_in : b_in;
    prod_nxt  = PROD_BITS'(mx) * PROD_BITS'(my);
    we        = (op_r == OP_WSUM) ? weight_t'(WEIGHT_ONE - wc_r) : wd_r;
    a_sx      = signed'({1'b0, a_in});
    b_sx      = signed'({1'b0, b_in});
    wpc_nxt   = wc_r * a_sx;
    wpd_nxt   = we * b_sx;
    ctrl1_nxt = '{op: op_r, clamp: clamp_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod1_r <= prod_nxt;
      wpc1_r  <= wpc_nxt;
      wpd1_r  <= wpd_nxt;
      ctrl1_r <= ctrl1_nxt;
      a1_r    <= a_in;
      b1_r    <= b_in;
    end
  end

  // stage 2: weighted sum, plain operations
  logic signed [WSUM_BITS-1:0] ws_nxt, ws2_r;
  result_t                     ax1, bx1, simple_nxt, simple2_r;
  ctrl_t                       ctrl2_r;
  sample_t                     a2_r;

  always_comb begin
    ws_nxt = WSUM_BITS'(wpc1_r) + WSUM_BITS'(wpd1_r) + WSUM_BITS'(WEIGHT_HALF);
    ax1    = {3'b000, a1_r};
    bx1    = {3'b000, b1_r};
    case (ctrl1_r.op) inside
      OP_MAX:    simple_nxt = (a1_r > b1_r) ? ax1 : bx1;
      OP_MIN:    simple_nxt = (a1_r < b1_r) ? ax1 : bx1;
      OP_ADD:    simple_nxt = ax1 + bx1;
      OP_SUB_AB: simple_nxt = ax1 - bx1;
      OP_SUB_BA: simple_nxt = bx1 - ax1;
      OP_AVG:    simple_nxt = (ax1 + bx1 + result_t'(1)) >>> 1;
      OP_MASK_B: simple_nxt = (b1_r != '0) ? ax1 : '0;
      OP_MASK_A: simple_nxt = (a1_r != '0) ? bx1 : '0;
      OP_PRIO_A: simple_nxt = (a1_r != '0) ? ax1 : bx1;
      OP_PRIO_B: simple_nxt = (b1_r != '0) ? bx1 : ax1;
      OP_TAKE_A: simple_nxt = ax1;
      OP_TAKE_B: simple_nxt = bx1;
      OP_MUL, OP_WSUM, OP_WSUM2, OP_OVER: simple_nxt = '0;
      default:   simple_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ws2_r     <= ws_nxt;
      simple2_r <= simple_nxt;
      ctrl2_r   <= ctrl1_r;
      a2_r      <= a1_r;
    end
  end

  // stages 2 and 3 of the rounded product
  sample_t quot;

  vpc_prod_round u_prod_round (
    .clk  (clk),
    .en   (adv),
    .prod (prod1_r),
    .quot (quot)
  );

  // stage 3: floor of the weighted sum
  result_t wres_nxt, wres3_r, simple3_r;
  ctrl_t   ctrl3_r;
  sample_t a3_r;

  assign wres_nxt = result_t'(ws2_r >>> WEIGHT_FRAC);

  always_ff @(posedge clk) begin
    if (adv) begin
      wres3_r   <= wres_nxt;
      simple3_r <= simple2_r;
      ctrl3_r   <= ctrl2_r;
      a3_r      <= a2_r;
    end
  end

  // stage 4: select and saturate into the output register
  result_t sel, out_data_nxt, out_data_r;
  result_t full_x;

  always_comb begin
    full_x = {3'b000, FULL};
    case (ctrl3_r.op) inside
      OP_MUL:             sel = {3'b000, quot};
      OP_OVER:            sel = {3'b000, a3_r} + {3'b000, quot};
      OP_WSUM, OP_WSUM2:  sel = wres3_r;
      default:            sel = simple3_r;
    endcase
    out_data_nxt = sel;
    if (ctrl3_r.clamp) begin
      if (sel < 0) begin
        out_data_nxt = '0;
      end else if (sel > full_x) begin
        out_data_nxt = full_x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tdata = OUT_TDATA_W'($unsigned(out_data_r));

endmodule

/* design/vpc_checker.sv */
module vpc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [vpc_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import vpc_pkg::*;

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // an accepted word reaches the output when the output is not stalled meanwhile
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready ##1 out_tready ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("accepted word did not reach the output");

  // reset drains the pipeline
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_tvalid)
    else $error("output valid straight after reset");

endmodule

bind voxel_pair_combiner vpc_checker u_vpc_checker (.*);
